### rtl/core/s512_pkg.sv
// Package for the SHA-512/256 hash block: constants, round table, helper functions.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
package s512_pkg;

  localparam int DIGEST_OUT_WORDS = 4;
  localparam int ROUNDS = 80;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam logic [63:0] INIT_HASH [8] = '{
    64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151,
    64'h963877195940eabd, 64'h96283ee2a88effe3, 64'hbe5e1e2553863992,
    64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2
  };

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

endpackage

### rtl/core/s512_front.sv
// Input queue of the hash block: a short FIFO of accepted requests.
// Depends on s512_pkg.
`timescale 1ns / 1ps
module s512_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  s512_pkg::item_t  in_item,
  output logic             full,
  output logic             q_valid,
  output s512_pkg::item_t  q_item,
  input  logic             q_take
);

  s512_pkg::item_t mem [s512_pkg::QDEPTH];
  logic [s512_pkg::QAW-1:0] wptr;
  logic [s512_pkg::QAW-1:0] rptr;
  logic [s512_pkg::QAW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (s512_pkg::QAW+1)'(s512_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_item = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + (s512_pkg::QAW+1)'(do_push) - (s512_pkg::QAW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> q_valid)
    else $error("queue full while empty");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (rst) count <= s512_pkg::QDEPTH)
    else $error("queue overflow");

endmodule

### rtl/core/s512_back.sv
// Compression engine: packs bytes, runs 80 rounds per block, pads, emits digest.
// Depends on s512_pkg.
`timescale 1ns / 1ps
module s512_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  s512_pkg::item_t  q_item,
  output logic             q_take,
  output logic             empty,
  input  logic             pop,
  output logic [63:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last
);

  s512_pkg::state_t state;
  s512_pkg::state_t state_next;
  logic [63:0] wbuf [16];
  logic [63:0] hw [8];
  logic [63:0] v [8];
  logic [6:0] byte_index;
  logic [63:0] byte_count;
  logic [6:0] rnd;
  logic finishing;
  logic pad_second;
  logic [2:0] emit_cnt;

  logic [63:0] w, t1, t2, s0, s1, w15, w2;
  logic [3:0] ri;
  logic [6:0] bi_next;
  logic byte_in;

  assign ri = rnd[3:0];
  assign byte_in = (state == s512_pkg::ST_IDLE) && q_valid;

  always_comb begin
    w15 = wbuf[ri + 4'd1];
    w2 = wbuf[ri + 4'd14];
    s0 = s512_pkg::rotr(w15, 1) ^ s512_pkg::rotr(w15, 8) ^ (w15 >> 7);
    s1 = s512_pkg::rotr(w2, 19) ^ s512_pkg::rotr(w2, 61) ^ (w2 >> 6);
    w = (rnd < 7'd16) ? wbuf[ri] : (wbuf[ri] + s0 + wbuf[ri + 4'd9] + s1);
    t1 = v[7] + (s512_pkg::rotr(v[4], 14) ^ s512_pkg::rotr(v[4], 18)
       ^ s512_pkg::rotr(v[4], 41)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
       + s512_pkg::ROUND_K[rnd] + w;
    t2 = (s512_pkg::rotr(v[0], 28) ^ s512_pkg::rotr(v[0], 34) ^ s512_pkg::rotr(v[0], 39))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    bi_next = byte_index + 7'd1;
  end

  always_comb begin
    state_next = state;
    case (state)
      s512_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == s512_pkg::KIND_FINISH) begin
            state_next = (byte_index > 7'd111) ? s512_pkg::ST_LOAD : s512_pkg::ST_PAD;
          end else if (byte_index == 7'd127) begin
            state_next = s512_pkg::ST_LOAD;
          end
        end
      end
      s512_pkg::ST_PAD: state_next = s512_pkg::ST_LOAD;
      s512_pkg::ST_LOAD: state_next = s512_pkg::ST_ROUND;
      s512_pkg::ST_ROUND: if (rnd == 7'(s512_pkg::ROUNDS - 1)) state_next = s512_pkg::ST_ADD;
      s512_pkg::ST_ADD: begin
        if (!finishing) state_next = s512_pkg::ST_IDLE;
        else if (pad_second) state_next = s512_pkg::ST_PAD;
        else state_next = s512_pkg::ST_EMIT;
      end
      s512_pkg::ST_EMIT: begin
        if (pop && emit_cnt == 3'(s512_pkg::DIGEST_OUT_WORDS - 1)) begin
          state_next = s512_pkg::ST_IDLE;
        end
      end
      default: state_next = s512_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = byte_in;
    empty = (state != s512_pkg::ST_EMIT);
    digest_word = hw[emit_cnt];
    word_index = emit_cnt[1:0];
    last = (emit_cnt == 3'(s512_pkg::DIGEST_OUT_WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s512_pkg::ST_IDLE;
      byte_index <= '0;
      byte_count <= '0;
      rnd <= '0;
      finishing <= 1'b0;
      pad_second <= 1'b0;
      emit_cnt <= '0;
      for (int i = 0; i < 16; i++) wbuf[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        hw[i] <= s512_pkg::INIT_HASH[i];
        v[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        s512_pkg::ST_IDLE: begin
          if (q_valid) begin
            wbuf[byte_index[6:3]][8*(7-byte_index[2:0]) +: 8] <=
              (q_item.kind == s512_pkg::KIND_FINISH) ? 8'h80 : q_item.data_byte;
            byte_index <= bi_next;
            if (q_item.kind == s512_pkg::KIND_FINISH) begin
              finishing <= 1'b1;
              pad_second <= (byte_index > 7'd111);
            end else begin
              finishing <= 1'b0;
              byte_count <= byte_count + 64'd1;
            end
          end
        end
        s512_pkg::ST_PAD: begin
          wbuf[14] <= {61'd0, byte_count[63:61]};
          wbuf[15] <= {byte_count[60:0], 3'b000};
          pad_second <= 1'b0;
        end
        s512_pkg::ST_LOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= hw[i];
          rnd <= '0;
        end
        s512_pkg::ST_ROUND: begin
          if (rnd >= 7'd16) wbuf[ri] <= w;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd <= rnd + 7'd1;
        end
        s512_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
          for (int i = 0; i < 16; i++) wbuf[i] <= '0;
          byte_index <= '0;
          emit_cnt <= '0;
        end
        s512_pkg::ST_EMIT: begin
          if (pop) begin
            emit_cnt <= emit_cnt + 3'd1;
            if (emit_cnt == 3'(s512_pkg::DIGEST_OUT_WORDS - 1)) begin
              byte_count <= '0;
              for (int i = 0; i < 8; i++) hw[i] <= s512_pkg::INIT_HASH[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == s512_pkg::ST_ROUND) |-> rnd < 7'(s512_pkg::ROUNDS))
    else $error("round counter out of range");
  assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == s512_pkg::ST_IDLE)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(emit_cnt) && !empty)
    else $error("result changed while stalled");

endmodule

### rtl/core/sha512_256_hash.sv
// SHA-512/256 hash block top level: input queue feeding the compression engine.
// Depends on s512_pkg, s512_front and s512_back.
//
// Requests enter through push/full: kind 0 carries a message byte, kind 1
// finishes the message. Results leave through empty/pop: a finish yields four
// 64-bit digest words, word_index 0 first, last set on the fourth.
// A byte is stored in the block buffer; the 128th byte of a block starts the load,
// 80 rounds at one per cycle, and the hash update. A finish runs the padding
// and these steps before the first word, twice when the padding needs an extra
// block. A single round datapath serves all 80 rounds.
// The four-entry input queue keeps taking requests while the engine runs.
// While the receiver holds pop low, the current word stays on the ports and
// the engine takes no new request; the queue fills and then raises full.
// Synchronous reset empties the queue, clears the block buffer and counters,
// and loads the initial hash values.
`timescale 1ns / 1ps
module sha512_256_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last
);

  s512_pkg::item_t in_item;
  s512_pkg::item_t q_item;
  logic q_valid;
  logic q_take;

  assign in_item.kind = kind;
  assign in_item.data_byte = data_byte;

  s512_front u_front (
    .clk(clk), .rst(rst), .push(push), .in_item(in_item), .full(full),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  s512_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .empty(empty), .pop(pop), .digest_word(digest_word),
    .word_index(word_index), .last(last)
  );

endmodule
